FILE: rtl/openpgp_packet_deframer_top_macros.svh
// Assertion macros for the OpenPGP packet deframer.
// Included by the RTL files that carry concurrent checks; no other dependency.
`ifndef OPENPGP_PACKET_DEFRAMER_TOP_MACROS_SVH
`define OPENPGP_PACKET_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("opd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("opd: next-cycle check failed");

`endif

FILE: rtl/opd_pkg.sv
// Shared types and constants for the OpenPGP packet deframer.
// No dependencies; used by every other RTL file but the assertion macro header.
package opd_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_OLDLEN = 3'd1,
      PH_NEW1   = 3'd2,
      PH_NEW2   = 3'd3,
      PH_NEW4   = 3'd4,
      PH_BODY   = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_HEADER = 3'd0,
      ST_BODY   = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_END    = 3'd3,
      ST_BADHDR = 3'd4,
      ST_INDET  = 3'd5,
      ST_TRUNC  = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic       last;
   } q_entry_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] HDR_BIT7      = 8'h80;
   localparam logic [7:0] TWO_BYTE_LO   = 8'd192;
   localparam logic [7:0] TWO_BYTE_HI   = 8'd223;
   localparam logic [7:0] FIVE_BYTE     = 8'd255;
   localparam logic [1:0] OLD_LEN_INDET = 2'd3;

endpackage

FILE: rtl/opd_interfaces.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on opd_pkg for the status type.
interface opd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       stream_end;
   modport source (output valid, output byte_in, output stream_end, input ready);
   modport sink   (input valid, input byte_in, input stream_end, output ready);
endinterface

interface opd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   opd_pkg::status_type status;
   logic               last;
   logic [31:0]        packet_length;
   modport source (output valid, output out_byte, output status, output last,
                   output packet_length, input ready);
   modport sink   (input valid, input out_byte, input status, input last,
                   input packet_length, output ready);
endinterface

FILE: rtl/opd_front.sv
// Front end: header and length parser that classifies each input word.
// Depends on opd_pkg, opd_interfaces and the assertion macro header.
`include "openpgp_packet_deframer_top_macros.svh"

module opd_front (
   input  logic                 clock,
   input  logic                 reset,
   opd_req_if.sink              req,
   input  logic                 q_full,
   output logic                 q_push,
   output opd_pkg::q_entry_type q_push_data
);

   opd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  left_ff, left_in;
   logic [7:0]  first_ff, first_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic        partial_ff, partial_in;

   logic        accept;
   logic [7:0]  b;
   logic        done;
   logic [31:0] done_len;
   logic        done_partial;
   logic [31:0] shift_acc;
   logic [2:0]  left_dec;
   logic [31:0] rem_dec;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.byte_in;
   assign shift_acc = {acc_ff[23:0], b};
   assign left_dec  = left_ff - 3'((left_ff != 3'd0) ? 1 : 0);
   assign rem_dec   = rem_ff - 32'((rem_ff != 32'd0) ? 1 : 0);

   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      partial_in   = partial_ff;
      q_push       = 1'b0;
      q_push_data  = '{data: 8'd0, status: opd_pkg::ST_END, last: 1'b1};
      done         = 1'b0;
      done_len     = 32'd0;
      done_partial = 1'b0;

      if (accept) begin
         if (phase_ff == opd_pkg::PH_IDLE) begin
            q_push = 1'b1;
            if (req.stream_end) begin
               q_push_data.status = opd_pkg::ST_END;
            end else if ((b & opd_pkg::HDR_BIT7) == 8'd0) begin
               q_push_data.status = opd_pkg::ST_BADHDR;
            end else if (b[6]) begin
               q_push_data = '{data: b, status: opd_pkg::ST_HEADER, last: 1'b0};
               phase_in    = opd_pkg::PH_NEW1;
            end else if (b[1:0] == opd_pkg::OLD_LEN_INDET) begin
               q_push_data.status = opd_pkg::ST_INDET;
            end else begin
               // Old format: the header is rewritten as bit 7 plus the 4-bit tag.
               q_push_data = '{data: {4'b1000, b[5:2]}, status: opd_pkg::ST_HEADER,
                               last: 1'b0};
               acc_in   = 32'd0;
               left_in  = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
               phase_in = opd_pkg::PH_OLDLEN;
            end
         end else if (req.stream_end) begin
            q_push     = 1'b1;
            q_push_data.status = opd_pkg::ST_TRUNC;
            phase_in   = opd_pkg::PH_IDLE;
            left_in    = 3'd0;
            acc_in     = 32'd0;
            rem_in     = 32'd0;
            partial_in = 1'b0;
         end else begin
            case (phase_ff)
               opd_pkg::PH_OLDLEN, opd_pkg::PH_NEW4: begin
                  acc_in  = shift_acc;
                  left_in = left_dec;
                  if (left_dec == 3'd0) begin
                     done     = 1'b1;
                     done_len = shift_acc;
                  end
               end
               opd_pkg::PH_NEW1: begin
                  if (b < opd_pkg::TWO_BYTE_LO) begin
                     done     = 1'b1;
                     done_len = {24'd0, b};
                  end else if (b <= opd_pkg::TWO_BYTE_HI) begin
                     first_in = b;
                     phase_in = opd_pkg::PH_NEW2;
                  end else if (b != opd_pkg::FIVE_BYTE) begin
                     done         = 1'b1;
                     done_len     = 32'd1 << b[4:0];
                     done_partial = 1'b1;
                  end else begin
                     acc_in   = 32'd0;
                     left_in  = 3'd4;
                     phase_in = opd_pkg::PH_NEW4;
                  end
               end
               opd_pkg::PH_NEW2: begin
                  // (first - 192) is just the low five bits of the first byte.
                  done     = 1'b1;
                  done_len = {19'd0, first_ff[4:0], b} + 32'(opd_pkg::TWO_BYTE_LO);
               end
               opd_pkg::PH_BODY: begin
                  q_push      = 1'b1;
                  q_push_data = '{data: b, status: opd_pkg::ST_BODY,
                                  last: (rem_dec == 32'd0) && !partial_ff};
                  rem_in = rem_dec;
                  if (rem_dec == 32'd0) begin
                     if (partial_ff) begin
                        partial_in = 1'b0;
                        phase_in   = opd_pkg::PH_NEW1;
                     end else begin
                        phase_in   = opd_pkg::PH_IDLE;
                        left_in    = 3'd0;
                        acc_in     = 32'd0;
                        partial_in = 1'b0;
                     end
                  end
               end
               default: begin
                  phase_in   = opd_pkg::PH_IDLE;
                  left_in    = 3'd0;
                  acc_in     = 32'd0;
                  rem_in     = 32'd0;
                  partial_in = 1'b0;
               end
            endcase

            if (done) begin
               if (done_len != 32'd0) begin
                  rem_in     = done_len;
                  partial_in = done_partial;
                  phase_in   = opd_pkg::PH_BODY;
               end else begin
                  // A zero length closes the packet with no body.
                  q_push     = 1'b1;
                  q_push_data.status = opd_pkg::ST_EMPTY;
                  phase_in   = opd_pkg::PH_IDLE;
                  left_in    = 3'd0;
                  acc_in     = 32'd0;
                  rem_in     = 32'd0;
                  partial_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= opd_pkg::PH_IDLE;
         left_ff    <= 3'd0;
         first_ff   <= 8'd0;
         acc_ff     <= 32'd0;
         rem_ff     <= 32'd0;
         partial_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         first_ff   <= first_in;
         acc_ff     <= acc_in;
         rem_ff     <= rem_in;
         partial_ff <= partial_in;
      end
   end

   `OPD_ASSERT_IMPL(a_body_has_bytes, clock, reset, phase_ff == opd_pkg::PH_BODY,
                    rem_ff != 32'd0)
   `OPD_ASSERT_IMPL(a_no_push_when_full, clock, reset, q_full, !q_push)

endmodule

FILE: rtl/opd_queue.sv
// Short result queue between the parser front end and the output back end.
// Depends on opd_pkg and the assertion macro header.
`include "openpgp_packet_deframer_top_macros.svh"

module opd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  opd_pkg::q_entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output opd_pkg::q_entry_type pop_data
);

   localparam int unsigned CNT_BITS = opd_pkg::QPTR_BITS + 1;

   opd_pkg::q_entry_type mem [opd_pkg::QUEUE_DEPTH];
   logic [opd_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [opd_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(opd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + opd_pkg::QPTR_BITS'(push ? 1 : 0);
      rd_ptr_in = rd_ptr_ff + opd_pkg::QPTR_BITS'(pop ? 1 : 0);
      count_in  = count_ff + CNT_BITS'(push ? 1 : 0) - CNT_BITS'(pop ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `OPD_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
                    count_ff <= CNT_BITS'(opd_pkg::QUEUE_DEPTH))
   `OPD_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, not_empty)

endmodule

FILE: rtl/opd_back.sv
// Back end: keeps the saturating packet byte count and drives the result register.
// Depends on opd_pkg, opd_interfaces and the assertion macro header.
`include "openpgp_packet_deframer_top_macros.svh"

module opd_back #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  opd_pkg::q_entry_type q_data,
   output logic                 q_pop,
   opd_rsp_if.source            rsp
);

   localparam int unsigned EXT_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   opd_pkg::status_type   status_ff, status_in;
   logic                  last_ff, last_in;
   logic [31:0]           plen_ff, plen_in;

   logic [COUNT_BITS-1:0] count_inc;
   logic [EXT_BITS-1:0]   cur_ext;
   logic [EXT_BITS-1:0]   inc_ext;
   logic [31:0]           cur_sat;
   logic [31:0]           inc_sat;

   assign count_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_BITS'(1);
   assign cur_ext   = EXT_BITS'(count_ff);
   assign inc_ext   = EXT_BITS'(count_inc);
   // The reported length is the count clipped to 32 bits.
   assign cur_sat   = (cur_ext > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cur_ext[31:0];
   assign inc_sat   = (inc_ext > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : inc_ext[31:0];

   assign q_pop = q_not_empty && (!valid_ff || rsp.ready);

   always_comb begin
      count_in  = count_ff;
      valid_in  = valid_ff && !rsp.ready;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      plen_in   = plen_ff;
      if (q_pop) begin
         valid_in  = 1'b1;
         byte_in   = q_data.data;
         status_in = q_data.status;
         last_in   = q_data.last;
         case (q_data.status)
            opd_pkg::ST_HEADER: begin
               count_in = COUNT_BITS'(1);
               plen_in  = 32'd1;
            end
            opd_pkg::ST_BODY: begin
               count_in = count_inc;
               plen_in  = inc_sat;
            end
            opd_pkg::ST_EMPTY, opd_pkg::ST_TRUNC: begin
               plen_in = cur_sat;
            end
            default: begin
               plen_in = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      plen_ff   <= plen_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_byte      = byte_ff;
   assign rsp.status        = status_ff;
   assign rsp.last          = last_ff;
   assign rsp.packet_length = plen_ff;

   `OPD_ASSERT_IMPL(a_header_len_one, clock, reset,
                    valid_ff && status_ff == opd_pkg::ST_HEADER, plen_ff == 32'd1)
   `OPD_ASSERT_NEXT(a_pop_loads_result, clock, reset, q_pop, valid_ff)

endmodule

FILE: rtl/openpgp_packet_deframer_top.sv
// OpenPGP packet deframer, top level.
//
// req channel: one word per item, either a stream byte (byte_in) or an
// end-of-stream mark (stream_end). rsp channel: at most one result per word,
// carrying out_byte, status, last and packet_length.
// Header bytes come out (old-format ones rewritten to 0x80 | tag), length
// bytes are consumed silently, body bytes pass through and the final one of
// a packet has last set. Errors and end marks produce a status-only result.
// The parser writes a word's result into the four-entry queue at the edge
// that accepts the word, and the queue loads it into the output register
// once that register is free.
// The parser accepts one word per cycle while the queue is not full, and
// keeps accepting while a result waits on rsp.
// When rsp stalls, the queue fills and req.ready drops once it is full.
// Synchronous reset returns the parser to idle, empties the queue and
// clears the output valid; no result is lost or repeated across a stall.
// Depends on opd_pkg, opd_interfaces, opd_front, opd_queue and opd_back.
module openpgp_packet_deframer_top #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   opd_req_if.sink   req,
   opd_rsp_if.source rsp
);

   logic                 q_full;
   logic                 q_push;
   opd_pkg::q_entry_type q_push_data;
   logic                 q_pop;
   logic                 q_not_empty;
   opd_pkg::q_entry_type q_pop_data;

   opd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   opd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   opd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule

FILE: tb/opd_deframer_checker.sv
// Checker for the OpenPGP packet deframer: predicts every result from the input words
// and compares each accepted result with the oldest prediction.
// Depends on opd_pkg and opd_interfaces.
module opd_deframer_checker #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   opd_req_if          req,
   opd_rsp_if          rsp,
   output int unsigned fail_count,
   output int unsigned pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]          data;
      opd_pkg::status_type status;
      logic                last;
      logic [31:0]         length;
   } deframed_word_type;

   deframed_word_type     expected_words[$];
   opd_pkg::phase_type    parse_phase;
   logic [2:0]            len_bytes_due;
   logic [7:0]            len_hi_byte;
   logic [31:0]           len_shift;
   logic [31:0]           body_due;
   logic                  in_partial;
   logic [COUNT_BITS-1:0] pkt_count;
   int unsigned           mismatches = 0;

   assign fail_count = mismatches;

   // The packet count is reported clipped to 32 bits.
   function automatic logic [31:0] count_seen();
      return (64'(pkt_count) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(pkt_count);
   endfunction

   task automatic queue_word(input logic [7:0] data, input opd_pkg::status_type status,
                             input logic last, input logic [31:0] length);
      expected_words.push_back('{data, status, last, length});
   endtask

   task automatic return_idle();
      parse_phase   = opd_pkg::PH_IDLE;
      len_bytes_due = 3'd0;
      len_shift     = 32'd0;
      body_due      = 32'd0;
      in_partial    = 1'b0;
   endtask

   task automatic length_decoded(input logic [31:0] len, input logic partial);
      in_partial = partial;
      body_due   = len;
      if (len != 32'd0) begin
         parse_phase = opd_pkg::PH_BODY;
      end else begin
         queue_word(8'h00, opd_pkg::ST_EMPTY, 1'b1, count_seen());
         return_idle();
      end
   endtask

   task automatic deframe_word(input logic [7:0] b, input logic eos);
      if (parse_phase == opd_pkg::PH_IDLE) begin
         if (eos) begin
            queue_word(8'h00, opd_pkg::ST_END, 1'b1, 32'd0);
         end else if ((b & opd_pkg::HDR_BIT7) == 8'h00) begin
            queue_word(8'h00, opd_pkg::ST_BADHDR, 1'b1, 32'd0);
         end else if (b[6]) begin
            // New-format header byte goes out unchanged.
            pkt_count   = COUNT_BITS'(1);
            parse_phase = opd_pkg::PH_NEW1;
            queue_word(b, opd_pkg::ST_HEADER, 1'b0, 32'd1);
         end else if (b[1:0] == opd_pkg::OLD_LEN_INDET) begin
            queue_word(8'h00, opd_pkg::ST_INDET, 1'b1, 32'd0);
         end else begin
            pkt_count     = COUNT_BITS'(1);
            len_shift     = 32'd0;
            len_bytes_due = (b[1:0] == 2'd0) ? 3'd1 : ((b[1:0] == 2'd1) ? 3'd2 : 3'd4);
            parse_phase   = opd_pkg::PH_OLDLEN;
            queue_word({4'h8, b[5:2]}, opd_pkg::ST_HEADER, 1'b0, 32'd1);
         end
      end else if (eos) begin
         queue_word(8'h00, opd_pkg::ST_TRUNC, 1'b1, count_seen());
         return_idle();
      end else begin
         case (parse_phase)
            opd_pkg::PH_OLDLEN, opd_pkg::PH_NEW4: begin
               len_shift = {len_shift[23:0], b};
               if (len_bytes_due != 3'd0) len_bytes_due--;
               if (len_bytes_due == 3'd0) length_decoded(len_shift, 1'b0);
            end
            opd_pkg::PH_NEW1: begin
               if (b < opd_pkg::TWO_BYTE_LO) begin
                  length_decoded(32'(b), 1'b0);
               end else if (b <= opd_pkg::TWO_BYTE_HI) begin
                  len_hi_byte = b;
                  parse_phase = opd_pkg::PH_NEW2;
               end else if (b < opd_pkg::FIVE_BYTE) begin
                  length_decoded(32'd1 << b[4:0], 1'b1);
               end else begin
                  len_shift     = 32'd0;
                  len_bytes_due = 3'd4;
                  parse_phase   = opd_pkg::PH_NEW4;
               end
            end
            opd_pkg::PH_NEW2: begin
               length_decoded((32'(len_hi_byte) - 32'(opd_pkg::TWO_BYTE_LO)) * 32'd256
                              + 32'(b) + 32'(opd_pkg::TWO_BYTE_LO), 1'b0);
            end
            opd_pkg::PH_BODY: begin
               if (pkt_count != '1) pkt_count++;
               if (body_due != 32'd0) body_due--;
               if (body_due != 32'd0) begin
                  queue_word(b, opd_pkg::ST_BODY, 1'b0, count_seen());
               end else if (in_partial) begin
                  // End of a partial chunk: another length header follows.
                  in_partial  = 1'b0;
                  parse_phase = opd_pkg::PH_NEW1;
                  queue_word(b, opd_pkg::ST_BODY, 1'b0, count_seen());
               end else begin
                  queue_word(b, opd_pkg::ST_BODY, 1'b1, count_seen());
                  return_idle();
               end
            end
            default: begin
               return_idle();
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      deframed_word_type want;
      if (reset) begin
         expected_words.delete();
         pkt_count   = '0;
         len_hi_byte = 8'h00;
         return_idle();
      end else begin
         if (req.valid && req.ready) deframe_word(req.byte_in, req.stream_end);
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: data %h status %0d last %b length %0d",
                           rsp.out_byte, rsp.status, rsp.last, rsp.packet_length);
               end
            end else begin
               want = expected_words.pop_front();
               if (rsp.out_byte !== want.data || rsp.status !== want.status ||
                   rsp.last !== want.last || rsp.packet_length !== want.length) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"result mismatch: expected data %h status %0d last %b ",
                               "length %0d, got data %h status %0d last %b length %0d"},
                              want.data, want.status, want.last, want.length,
                              rsp.out_byte, rsp.status, rsp.last, rsp.packet_length);
                  end
               end
            end
         end
      end
      pending_results <= expected_words.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the OpenPGP packet deframer testbench: clock, reset, byte stimulus with random
// idling and result stalls, a watchdog and the verdict.
// Depends on opd_pkg, opd_interfaces, the deframer RTL and opd_deframer_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 1650;
   localparam int unsigned CALM_WORDS   = 300;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES  = 10;
   localparam logic [8:0]  END_MARK     = 9'h100;

   // Bit 8 of a stimulus word is the end-of-stream mark.
   localparam logic [8:0] DIRECTED_WORDS [25] = '{
      END_MARK,
      9'h000, 9'h07F,
      9'h0BF,
      9'h080, 9'h000,
      9'h0BD, 9'h000, 9'h001, 9'h0FF,
      9'h0C0, 9'h0E0, 9'h05A, 9'h000,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0A5, END_MARK,
      9'h0C1, 9'h0DF, END_MARK
   };

   logic        clock;
   logic        reset = 1'b1;
   bit          req_idle_on = 1'b0;
   bit          rsp_stall_on = 1'b0;
   int unsigned words_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned fail_count;
   int unsigned pending_results;
   logic [8:0]  packet_words[$];
   int unsigned body_budget;
   bit          packet_cut;

   opd_req_if req_ch ();
   opd_rsp_if rsp_ch ();

   openpgp_packet_deframer_top #(.COUNT_BITS(32)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   opd_deframer_checker #(.COUNT_BITS(32)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [8:0] w);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.byte_in    <= w[7:0];
      req_ch.stream_end <= w[8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain_pause();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_results == 0);
   endtask

   // A length beyond what is left of the body budget is cut short and the
   // packet ends with a truncating end mark.
   task automatic add_body(input logic [31:0] len);
      int unsigned n;
      if (len > body_budget) begin
         n = $urandom_range(0, (body_budget < 8) ? body_budget : 8);
         packet_cut = 1'b1;
      end else begin
         n = len;
      end
      repeat (n) packet_words.push_back({1'b0, 8'($urandom)});
      body_budget -= n;
   endtask

   function automatic logic [31:0] pick_len(input logic [31:0] mask);
      if ($urandom_range(0, 15) == 0) return $urandom & mask;
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return $urandom_range(9, 40);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   task automatic send_packet();
      logic [31:0] len;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [1:0]  len_form;
      int unsigned cut_at;
      packet_words.delete();
      body_budget = 450;
      packet_cut  = 1'b0;
      if ($urandom_range(0, 1)) begin
         len_form = 2'($urandom_range(0, 2));
         packet_words.push_back({1'b0, 2'b10, 4'($urandom), len_form});
         case (len_form)
            2'd0: begin
               len = pick_len(32'hFF);
               packet_words.push_back({1'b0, len[7:0]});
            end
            2'd1: begin
               len = pick_len(32'hFFFF);
               packet_words.push_back({1'b0, len[15:8]});
               packet_words.push_back({1'b0, len[7:0]});
            end
            default: begin
               len = pick_len(32'hFFFF_FFFF);
               for (int i = 3; i >= 0; i--) packet_words.push_back({1'b0, len[8*i +: 8]});
            end
         endcase
         add_body(len);
      end else begin
         packet_words.push_back({1'b0, 2'b11, 6'($urandom)});
         // Partial chunks are mostly short; a long one ends in truncation.
         while (!packet_cut && $urandom_range(0, 3) == 0) begin
            hi = 8'd224 + 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 30)
                                                          : $urandom_range(0, 4));
            packet_words.push_back({1'b0, hi});
            add_body(32'd1 << hi[4:0]);
         end
         if (!packet_cut) begin
            case ($urandom_range(0, 19))
               0: begin
                  hi = ($urandom_range(0, 2) == 0)
                       ? 8'($urandom_range(opd_pkg::TWO_BYTE_LO, opd_pkg::TWO_BYTE_HI))
                       : opd_pkg::TWO_BYTE_LO;
                  lo = 8'($urandom);
                  len = (32'(hi) - 32'(opd_pkg::TWO_BYTE_LO)) * 32'd256 + 32'(lo)
                        + 32'(opd_pkg::TWO_BYTE_LO);
                  packet_words.push_back({1'b0, hi});
                  packet_words.push_back({1'b0, lo});
               end
               1, 2, 3: begin
                  len = pick_len(32'hFFFF_FFFF);
                  packet_words.push_back({1'b0, opd_pkg::FIVE_BYTE});
                  for (int i = 3; i >= 0; i--) packet_words.push_back({1'b0, len[8*i +: 8]});
               end
               default: begin
                  len = pick_len(32'hFF);
                  if (len > 32'd191) len = 32'd191;
                  packet_words.push_back({1'b0, len[7:0]});
               end
            endcase
            add_body(len);
         end
      end
      if (!packet_cut && packet_words.size() > 1 && $urandom_range(0, 15) == 0) begin
         cut_at = $urandom_range(1, packet_words.size() - 1);
         while (packet_words.size() > cut_at) void'(packet_words.pop_back());
         packet_cut = 1'b1;
      end
      if (packet_cut) packet_words.push_back({1'b1, 8'($urandom)});
      foreach (packet_words[i]) send_word(packet_words[i]);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 3))
         0:       send_word({1'b0, 1'b0, 7'($urandom)});
         1:       send_word({1'b0, 2'b10, 4'($urandom), opd_pkg::OLD_LEN_INDET});
         2:       send_word({1'b1, 8'($urandom)});
         default: send_word({1'b0, 8'($urandom)});
      endcase
   endtask

   initial begin
      int unsigned stop_at;
      int unsigned calm_at;
      int unsigned block;
      req_ch.valid      = 1'b0;
      req_ch.byte_in    = 8'h00;
      req_ch.stream_end = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i]);
      drain_pause();
      stop_at = words_sent + RANDOM_WORDS;
      calm_at = stop_at - CALM_WORDS;
      block   = 0;
      while (words_sent < stop_at) begin
         if (words_sent >= calm_at) begin
            req_idle_on  = 1'b0;
            rsp_stall_on = 1'b0;
         end else if (words_sent / 250 != block) begin
            block        = words_sent / 250;
            req_idle_on  = ($urandom_range(0, 2) != 0);
            rsp_stall_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_packet();
         if ($urandom_range(0, 39) == 0) drain_pause();
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/opd_pkg.sv
rtl/opd_interfaces.sv
rtl/opd_front.sv
rtl/opd_queue.sv
rtl/opd_back.sv
rtl/openpgp_packet_deframer_top.sv
tb/opd_deframer_checker.sv
tb/testbench.sv
